### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define DEQ_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/deq_pkg.sv
// Package for the double-ended queue: defaults, command and status codes,
// and the stage record used inside the core. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int VALUE_PORT_W    = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH_LEFT  = 3'd0;
    localparam t_cmd CMD_PUSH_RIGHT = 3'd1;
    localparam t_cmd CMD_POP_LEFT   = 3'd2;
    localparam t_cmd CMD_POP_RIGHT  = 3'd3;
    localparam t_cmd CMD_STATUS     = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Result bookkeeping carried alongside the memory read.
    typedef struct packed {
        logic    pop_ok;
        t_status status;
        logic    empty;
    } t_stage;

endpackage

### sv/deq_if.sv
// Channel interfaces of the double-ended queue: command in, result out.
// Depends on deq_pkg for field widths.
`timescale 1ns / 1ps

interface deq_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::CMD_W-1:0]          command;
    logic [deq_pkg::VALUE_PORT_W-1:0]   push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_res_if;
    logic                               valid;
    logic                               ready;
    logic [deq_pkg::VALUE_PORT_W-1:0]   pop_value;
    logic [deq_pkg::STATUS_W-1:0]       status;
    logic                               is_empty;

    modport source (output valid, output pop_value, output status, output is_empty,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input is_empty,
                    output ready);
endinterface

### sv/double_ended_queue_core.sv
// Double-ended queue core: pointer logic around the element store.
// Depends on deq_pkg, deq_if (channels) and deq_store.
//
// Usage:
//   i_cmd carries one command per transfer: push left, push right, pop left,
//   pop right or status query (codes 5..7 act as a query). push_value is
//   used by pushes only.
//   o_res returns exactly one result per command, in order: pop_value
//   (zero unless a pop succeeded), status (done, pop on empty, push on
//   full dropped) and is_empty after the command.
//   The stage record and the store read data are registered when the command
//   transfers; the output register then takes them once it is free.
//   Throughput: one command per cycle unless o_res stalls, set by the single
//   write and read port of the store; a pop reads what the previous cycle wrote.
//   Reset (synchronous, active low) empties the deque and drops any result
//   in flight; store contents are left as they are and never read unwritten.
//   When the receiver stalls, the output register holds its result and one
//   more command may enter; after that i_cmd.ready stays low.
`timescale 1ns / 1ps

module double_ended_queue_core #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_cmd_if.sink    i_cmd,
    deq_res_if.source  o_res
);

    localparam int PORT_W  = deq_pkg::VALUE_PORT_W;
    localparam int STORE_W = (VALUE_WIDTH < PORT_W) ? VALUE_WIDTH : PORT_W;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    logic [IDX_W-1:0]   r_left,  n_left;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_s1_valid;
    deq_pkg::t_stage    r_s1, n_s1;

    logic               r_out_valid;
    logic [PORT_W-1:0]  r_out_value;
    deq_pkg::t_status   r_out_status;
    logic               r_out_empty;

    logic               cmd_acc, out_free, s1_move;
    logic               is_full, is_empt;
    logic [IDX_W-1:0]   left_dec, left_inc, pos_push, pos_pop;
    logic [SUM_W-1:0]   sum_push, sum_pop;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic [STORE_W-1:0] rd_data;

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_cmd.ready = !r_s1_valid || out_free;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    assign is_full = (r_count == CNT_W'(DEPTH));
    assign is_empt = (r_count == '0);

    assign left_dec = (r_left == '0) ? IDX_W'(DEPTH - 1) : r_left - 1'b1;
    assign left_inc = (r_left == IDX_W'(DEPTH - 1)) ? '0 : r_left + 1'b1;

    // Right end positions: left + count (next free), left + count - 1 (last held).
    assign sum_push = SUM_W'(r_left) + SUM_W'(r_count);
    assign sum_pop  = sum_push - 1'b1;
    assign pos_push = (sum_push >= SUM_W'(DEPTH)) ? IDX_W'(sum_push - SUM_W'(DEPTH))
                                                   : sum_push[IDX_W-1:0];
    assign pos_pop  = (sum_pop >= SUM_W'(DEPTH))  ? IDX_W'(sum_pop - SUM_W'(DEPTH))
                                                   : sum_pop[IDX_W-1:0];

    always_comb begin
        n_left        = r_left;
        n_count       = r_count;
        wr_en         = 1'b0;
        wr_addr       = pos_push;
        rd_en         = 1'b0;
        rd_addr       = r_left;
        n_s1.pop_ok   = 1'b0;
        n_s1.status   = deq_pkg::ST_DONE;
        case (i_cmd.command)
            deq_pkg::CMD_PUSH_LEFT, deq_pkg::CMD_PUSH_RIGHT: begin
                if (is_full) begin
                    n_s1.status = deq_pkg::ST_FULL;
                end else begin
                    wr_en   = cmd_acc;
                    n_count = r_count + 1'b1;
                    if (i_cmd.command == deq_pkg::CMD_PUSH_LEFT) begin
                        n_left  = left_dec;
                        wr_addr = left_dec;
                    end
                end
            end
            deq_pkg::CMD_POP_LEFT, deq_pkg::CMD_POP_RIGHT: begin
                if (is_empt) begin
                    n_s1.status = deq_pkg::ST_EMPTY;
                end else begin
                    rd_en       = cmd_acc;
                    n_s1.pop_ok = 1'b1;
                    n_count     = r_count - 1'b1;
                    if (i_cmd.command == deq_pkg::CMD_POP_LEFT) begin
                        n_left = left_inc;
                    end else begin
                        rd_addr = pos_pop;
                    end
                end
            end
            default: begin
            end
        endcase
        n_s1.empty = (n_count == '0);
    end

    deq_store #(
        .DEPTH  (DEPTH),
        .DATA_W (STORE_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.push_value[STORE_W-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd_acc) begin
                r_left  <= n_left;
                r_count <= n_count;
            end
            if (cmd_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_value  <= r_s1.pop_ok ? PORT_W'(rd_data) : '0;
            r_out_status <= r_s1.status;
            r_out_empty  <= r_s1.empty;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.pop_value = r_out_value;
    assign o_res.status    = r_out_status;
    assign o_res.is_empty  = r_out_empty;

endmodule

### sv/deq_store.sv
// Element store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module deq_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/deq_checker.sv
// Port-level checker for double_ended_queue_core, attached by bind.
// Depends on deq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cmd_valid,
    input logic                               i_cmd_ready,
    input logic                               i_res_valid,
    input logic                               i_res_ready,
    input logic [deq_pkg::VALUE_PORT_W-1:0]   i_pop_value,
    input logic [deq_pkg::STATUS_W-1:0]       i_status,
    input logic                               i_is_empty
);

    logic       cmd_xfer, res_xfer;
    logic [1:0] r_inflight;

    assign cmd_xfer = i_cmd_valid && i_cmd_ready;
    assign res_xfer = i_res_valid && i_res_ready;

    // Commands taken minus results delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 2'(cmd_xfer) - 2'(res_xfer);
        end
    end

    `DEQ_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    `DEQ_ASSERT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable({i_pop_value, i_status, i_is_empty}), "stalled result changed")

    `DEQ_ASSERT(a_inflight_max, i_clk, i_rst_n, r_inflight != 2'd3, "more than two commands in flight")

    `DEQ_ASSERT(a_no_spurious, i_clk, i_rst_n, i_res_valid |-> r_inflight != 2'd0, "result without a pending command")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_pop_value (o_res.pop_value),
    .i_status    (o_res.status),
    .i_is_empty  (o_res.is_empty)
);

### tb/sv/deq_result_checker.sv
// Result checker for the double-ended queue: watches both channels, keeps a
// shadow deque, predicts each result and compares it field by field.
// Depends on deq_pkg and deq_if.
`timescale 1ns / 1ps

module deq_result_checker
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    deq_cmd_if   i_cmd_mon,
    deq_res_if   i_res_mon,
    output int   o_fail_count,
    output int   o_awaited,
    output int   o_cmd_total,
    output int   o_full_drops,
    output int   o_empty_pops
);

    localparam int DEPTH       = DEPTH_DEF;
    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam logic [VALUE_PORT_W-1:0] VALUE_MASK = {VALUE_WIDTH{1'b1}};

    typedef struct packed {
        logic [VALUE_PORT_W-1:0] pop_value;
        t_status                 status;
        logic                    is_empty;
    } t_deq_result;

    logic [VALUE_PORT_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]        left_slot;
    logic [CNT_W-1:0]        fill_level;
    t_deq_result             awaited_results [$];

    int mismatches    = 0;
    int commands_seen = 0;
    int full_drops    = 0;
    int empty_pops    = 0;

    // Store slot that lies offset places right of the left end, wrapped.
    function automatic logic [IDX_W-1:0] slot_from_left(input int offset);
        return IDX_W'((int'(left_slot) + offset) % DEPTH);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic predict_command(input t_cmd cmd, input logic [VALUE_PORT_W-1:0] value,
                                   output t_deq_result res);
        res        = '0;
        res.status = ST_DONE;
        case (cmd)
            CMD_PUSH_LEFT, CMD_PUSH_RIGHT: begin
                if (fill_level >= CNT_W'(DEPTH)) begin
                    res.status = ST_FULL;
                    full_drops++;
                end else if (cmd == CMD_PUSH_LEFT) begin
                    left_slot               = slot_from_left(DEPTH - 1);
                    shadow_store[left_slot] = value & VALUE_MASK;
                    fill_level++;
                end else begin
                    shadow_store[slot_from_left(int'(fill_level))] = value & VALUE_MASK;
                    fill_level++;
                end
            end
            CMD_POP_LEFT, CMD_POP_RIGHT: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                    empty_pops++;
                end else if (cmd == CMD_POP_LEFT) begin
                    res.pop_value = shadow_store[left_slot];
                    left_slot     = slot_from_left(1);
                    fill_level--;
                end else begin
                    res.pop_value = shadow_store[slot_from_left(int'(fill_level) - 1)];
                    fill_level--;
                end
            end
            default: ;  // status query and unused codes change nothing
        endcase
        res.pop_value = res.pop_value & VALUE_MASK;
        res.is_empty  = (fill_level == 0);
    endtask

    always @(posedge i_clk) begin : monitor
        t_deq_result want;
        if (!i_rst_n) begin
            left_slot  = '0;
            fill_level = '0;
            awaited_results.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result transfer 0x%08h with no command waiting",
                                              i_res_mon.pop_value));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res_mon.pop_value !== want.pop_value)
                        report_mismatch($sformatf("pop_value 0x%08h, expected 0x%08h",
                                                  i_res_mon.pop_value, want.pop_value));
                    if (i_res_mon.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_res_mon.status, want.status));
                    if (i_res_mon.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %0b, expected %0b",
                                                  i_res_mon.is_empty, want.is_empty));
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                predict_command(i_cmd_mon.command, i_cmd_mon.push_value, want);
                awaited_results.push_back(want);
                commands_seen++;
            end
        end
        o_fail_count <= mismatches;
        o_awaited    <= awaited_results.size();
        o_cmd_total  <= commands_seen;
        o_full_drops <= full_drops;
        o_empty_pops <= empty_pops;
    end

endmodule

### tb/sv/tb_double_ended_queue_core.sv
// Top of the double-ended queue testbench: clock, reset, command stimulus
// with bursts, receiver stalls and the verdict. Checking is in deq_result_checker.
// Depends on deq_pkg, deq_if, double_ended_queue_core and deq_result_checker.
`timescale 1ns / 1ps

module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam int RANDOM_ITEMS    = 1700;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int TAIL_CYCLES     = 20;
    localparam int FULL_DEPTH      = DEPTH_DEF;

    logic i_clk;
    logic i_rst_n;

    deq_cmd_if cmd_ch ();
    deq_res_if res_ch ();

    int fail_count;
    int awaited;
    int cmd_total;
    int full_drops;
    int empty_pops;

    int burst_left       = 0;
    bit hold_off_pending = 0;
    int pattern_tick     = 0;

    double_ended_queue_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    deq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_awaited    (awaited),
        .o_cmd_total  (cmd_total),
        .o_full_drops (full_drops),
        .o_empty_pops (empty_pops)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout: results still outstanding");
        $display("tb_double_ended_queue_core NOT OK");
        $finish;
    end

    function automatic logic [VALUE_PORT_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_PORT_W'(1);
            3:       return {1'b1, {(VALUE_PORT_W-1){1'b0}}};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd pick_command(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return t_cmd'($urandom_range(int'(CMD_STATUS), (1 << CMD_W) - 1));
        if (roll < 4 + push_pct * 96 / 100)
            return $urandom_range(0, 1) ? CMD_PUSH_RIGHT : CMD_PUSH_LEFT;
        return $urandom_range(0, 1) ? CMD_POP_RIGHT : CMD_POP_LEFT;
    endfunction

    // Offer one command and wait for its transfer; gaps fall between bursts.
    task automatic send_command(input t_cmd cmd, input logic [VALUE_PORT_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 160);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                cmd_ch.valid      <= 1'b0;
                cmd_ch.command    <= t_cmd'($urandom);
                cmd_ch.push_value <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.push_value <= value;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // Receiver: stall pattern changes every span; one long hold-off on request.
    initial begin
        int stall_mode;
        int span;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall_mode = $urandom_range(0, 3);
            span       = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                pattern_tick++;
                if (hold_off_pending) begin
                    res_ch.ready <= 1'b0;
                    for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge i_clk);
                    hold_off_pending = 1'b0;
                end else begin
                    case (stall_mode)
                        0:       res_ch.ready <= 1'b1;
                        1:       res_ch.ready <= 1'($urandom_range(0, 1));
                        2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: res_ch.ready <= ((pattern_tick % 5) < 3);
                    endcase
                end
            end
        end
    end

    initial begin
        int sent;
        int phase_len;
        int push_pct;
        int hold_off_at;

        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_STATUS;
        cmd_ch.push_value <= '0;
        res_ch.ready      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pops on empty, query and unused code, fill to full with
        // wrap on the left, pushes refused at both ends, then pops.
        send_command(CMD_POP_LEFT, '1);
        send_command(CMD_POP_RIGHT, '0);
        send_command(CMD_STATUS, '1);
        send_command(t_cmd'('1), '1);
        for (int i = 0; i < FULL_DEPTH; i++) begin
            send_command((i % 2 == 0) ? CMD_PUSH_LEFT : CMD_PUSH_RIGHT,
                         (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
        end
        send_command(CMD_PUSH_LEFT, '1);
        send_command(CMD_PUSH_RIGHT, '0);
        send_command(CMD_POP_LEFT, $urandom);
        send_command(CMD_POP_RIGHT, $urandom);

        // Random phases, each leaning toward pushes or pops so the deque
        // swings between empty and full.
        hold_off_at = $urandom_range(300, 900);
        sent        = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       push_pct = 10;
                1:       push_pct = 30;
                2:       push_pct = 50;
                3:       push_pct = 70;
                default: push_pct = 90;
            endcase
            phase_len = $urandom_range(16, 64);
            repeat (phase_len) begin
                if (sent == hold_off_at)
                    hold_off_pending = 1'b1;
                send_command(pick_command(push_pct), pick_value());
                sent++;
            end
        end
        cmd_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d commands transferred: %0d pushes refused while full, %0d pops on empty.",
                 cmd_total, full_drops, empty_pops);
        $display("Receiver held off %0d cycles once while commands kept coming.",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && awaited == 0) begin
            $display("tb_double_ended_queue_core OK");
        end else begin
            $display("tb_double_ended_queue_core NOT OK");
        end
        $finish;
    end

endmodule
